/* src/ieqnf_pkg.sv */
`timescale 1ns / 1ps
package ieqnf_pkg;

   localparam int DEV_W    = 10;
   localparam int VAL_W    = 16;
   localparam int HELD_W   = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [2:0] {
      ACT_POST      = 3'd0,
      ACT_READ      = 3'd1,
      ACT_PEEK      = 3'd2,
      ACT_CLEAR     = 3'd3,
      ACT_SET_LEVEL = 3'd4,
      ACT_SET_NOISE = 3'd5,
      ACT_GET_LEVEL = 3'd6,
      ACT_SET_EN    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      STS_DONE       = 3'd0,
      STS_FILTERED   = 3'd1,
      STS_DUPLICATE  = 3'd2,
      STS_FULL_DROP  = 3'd3,
      STS_FULL_MARK  = 3'd4,
      STS_EMPTY      = 3'd5
   } status_type;

   typedef enum logic {
      REG_REDRAW_CODE = 1'b0,
      REG_FULL_CODE   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FULL
   } state_type;

   typedef struct packed {
      logic              enable;
      logic [VAL_W-1:0]  threshold;
      logic [VAL_W-1:0]  reported;
      logic [VAL_W-1:0]  level;
   } dev_rec_type;

   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [DEV_W-1:0]  device;
   } ring_entry_type;

   localparam logic [DEV_W-1:0] REDRAW_CODE_RESET = 10'd528;
   localparam logic [DEV_W-1:0] FULL_CODE_RESET   = 10'd531;

endpackage

/* src/input_event_queue_noise_filter.sv */
`timescale 1ns / 1ps
// Input-event queue with per-device noise filtering.
// req_ channel: one action per transfer; req_tuser is the action code, req_tdata
// carries device code, value and the filter flag. rsp_ channel: exactly one
// result per action; rsp_tuser is the status, rsp_tdata carries the entry
// device, value and the number of queued entries after the action.
// csr_ channel: register writes (index 0 redraw code, 1 full-marker code),
// always ready, to be issued only while no action is in flight.
// Flow: the per-device record and the ring slot are read in the accept
// cycle and written back in the EXEC state, which holds until the output
// register is free. A non-duplicate post that passes the filter onto a full
// queue goes through the FULL state to read the enable bit of the
// full-marker device, since the device table has one read port.
// Reset: the per-device table is zeroed by a sweep over all NUM_DEVICES
// entries; req_tready stays low until it completes. The ring is not cleared.
// When rsp_tready is low, one result waits in the output register; the next
// action is still taken and its processing holds until that register drains.
module input_event_queue_noise_filter #(
   parameter int NUM_DEVICES = 1024,
   parameter int QUEUE_SLOTS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] device_code, [25:10] value, [26] filtered, [31:27] zero
   input  logic [ieqnf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] action
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] out_device, [25:10] out_value, [32:26] entries_held, [39:33] zero
   output logic [ieqnf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [2:0] status
   output logic [2:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [ieqnf_pkg::DEV_W-1:0]         csr_data
);
   import ieqnf_pkg::*;

   localparam int AW  = $clog2(NUM_DEVICES);
   localparam int RAW = $clog2(QUEUE_SLOTS);

   state_type              state_ff, state_in;
   action_type             act_ff;
   logic [DEV_W-1:0]       dev_ff;
   logic [VAL_W-1:0]       val_ff;
   logic                   filt_ff;
   logic [RAW-1:0]         head_ff, head_in;
   logic [RAW-1:0]         count_ff, count_in;
   logic [DEV_W-1:0]       redraw_ff;
   logic [DEV_W-1:0]       fullc_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [DEV_W-1:0]       rsp_dev_ff;
   logic [VAL_W-1:0]       rsp_val_ff;
   logic [HELD_W-1:0]      rsp_held_ff;

   logic                   accept;
   logic                   rsp_free;
   logic                   rsp_load;
   status_type             o_status;
   logic [DEV_W-1:0]       o_dev;
   logic [VAL_W-1:0]       o_val;

   logic                   tbl_ready;
   logic                   tbl_rd_en;
   logic [AW-1:0]          tbl_rd_addr;
   dev_rec_type            tbl_rd_data;
   logic                   tbl_wr_en;
   dev_rec_type            tbl_wr_data;

   ring_entry_type         ring_mem [QUEUE_SLOTS];
   ring_entry_type         ring_rd_ff;
   logic                   ring_rd_en;
   logic [RAW-1:0]         ring_rd_addr;
   logic                   ring_wr_en;
   logic [RAW-1:0]         ring_wr_addr;
   ring_entry_type         ring_wr_data;

   logic [RAW:0]           tail_sum;
   logic [RAW-1:0]         tail_slot;
   logic [RAW-1:0]         newest_slot;
   logic [RAW-1:0]         head_next;
   logic                   q_full;

   logic                   dev_ok;
   logic                   fullc_ok;
   logic [VAL_W-1:0]       lvl;
   logic [VAL_W-1:0]       rep;
   logic [VAL_W-1:0]       thr;
   logic [VAL_W-1:0]       diff;
   logic [VAL_W:0]         diff_x;
   logic [VAL_W:0]         mag;
   logic                   filt_out;
   logic                   dup;

   ieqnf_dev_table #(
      .NUM_DEVICES (NUM_DEVICES)
   ) u_dev_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(dev_ff)),
      .wr_data (tbl_wr_data),
      .ready   (tbl_ready)
   );

   // ring slot arithmetic, all operands below QUEUE_SLOTS
   always_comb begin
      tail_sum    = {1'b0, head_ff} + {1'b0, count_ff};
      tail_slot   = (tail_sum >= (RAW+1)'(QUEUE_SLOTS))
                    ? RAW'(tail_sum - (RAW+1)'(QUEUE_SLOTS)) : RAW'(tail_sum);
      newest_slot = (tail_slot == '0) ? RAW'(QUEUE_SLOTS - 1) : tail_slot - 1'b1;
      head_next   = (head_ff == RAW'(QUEUE_SLOTS - 1)) ? '0 : head_ff + 1'b1;
      q_full      = (count_ff == RAW'(QUEUE_SLOTS - 1));
   end

   // noise filter and duplicate check on the fetched record
   always_comb begin
      dev_ok   = (32'(dev_ff) < NUM_DEVICES);
      fullc_ok = (32'(fullc_ff) < NUM_DEVICES);
      lvl      = dev_ok ? tbl_rd_data.level     : '0;
      rep      = dev_ok ? tbl_rd_data.reported  : '0;
      thr      = dev_ok ? tbl_rd_data.threshold : '0;
      diff     = lvl - rep;
      diff_x   = {diff[VAL_W-1], diff};
      mag      = diff_x[VAL_W] ? (~diff_x + 1'b1) : diff_x;
      filt_out = filt_ff && ($signed(mag) < $signed({thr[VAL_W-1], thr}));
      dup      = (count_ff != '0) && (dev_ff == redraw_ff) &&
                 (ring_rd_ff.device == dev_ff) && (ring_rd_ff.value == val_ff);
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      accept       = 1'b0;
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = AW'(req_tdata[DEV_W-1:0]);
      tbl_wr_en    = 1'b0;
      tbl_wr_data  = tbl_rd_data;
      ring_rd_en   = 1'b0;
      ring_rd_addr = (action_type'(req_tuser) == ACT_POST) ? newest_slot : head_ff;
      ring_wr_en   = 1'b0;
      ring_wr_addr = tail_slot;
      ring_wr_data = '{value: val_ff, device: dev_ff};
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_load     = 1'b0;
      o_status     = STS_DONE;
      o_dev        = '0;
      o_val        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = tbl_ready;
            accept     = tbl_ready && req_tvalid;
            if (accept) begin
               tbl_rd_en  = 1'b1;
               ring_rd_en = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               unique case (act_ff)
                  ACT_POST: begin
                     if (filt_out) begin
                        o_status = STS_FILTERED;
                     end else begin
                        tbl_wr_en            = dev_ok;
                        tbl_wr_data.reported = lvl;
                        if (dup) begin
                           o_status = STS_DUPLICATE;
                        end else if (!q_full) begin
                           ring_wr_en = 1'b1;
                           count_in   = count_ff + 1'b1;
                        end else begin
                           rsp_load    = 1'b0;
                           tbl_rd_en   = 1'b1;
                           tbl_rd_addr = AW'(fullc_ff);
                           state_in    = ST_FULL;
                        end
                     end
                  end
                  ACT_READ, ACT_PEEK: begin
                     if (count_ff == '0) begin
                        o_status = STS_EMPTY;
                     end else begin
                        o_dev = ring_rd_ff.device;
                        if (act_ff == ACT_READ) begin
                           o_val    = ring_rd_ff.value;
                           head_in  = head_next;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_SET_LEVEL: begin
                     tbl_wr_en         = dev_ok;
                     tbl_wr_data.level = val_ff;
                  end
                  ACT_SET_NOISE: begin
                     tbl_wr_en             = dev_ok;
                     tbl_wr_data.threshold = val_ff;
                     tbl_wr_data.reported  = tbl_rd_data.level;
                  end
                  ACT_GET_LEVEL: begin
                     o_val = lvl;
                  end
                  ACT_SET_EN: begin
                     tbl_wr_en          = dev_ok;
                     tbl_wr_data.enable = val_ff[0];
                  end
               endcase
            end
         end
         ST_FULL: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (fullc_ok && tbl_rd_data.enable) begin
                  ring_wr_en   = 1'b1;
                  ring_wr_addr = newest_slot;
                  ring_wr_data = '{value: VAL_W'(1), device: fullc_ff};
                  o_status     = STS_FULL_MARK;
               end else begin
                  o_status = STS_FULL_DROP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         redraw_ff    <= REDRAW_CODE_RESET;
         fullc_ff     <= FULL_CODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               REG_REDRAW_CODE: redraw_ff <= csr_data;
               REG_FULL_CODE:   fullc_ff  <= csr_data;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= action_type'(req_tuser);
         dev_ff  <= req_tdata[DEV_W-1:0];
         val_ff  <= req_tdata[DEV_W +: VAL_W];
         filt_ff <= req_tdata[DEV_W+VAL_W];
      end
      if (rsp_load) begin
         rsp_status_ff <= o_status;
         rsp_dev_ff    <= o_dev;
         rsp_val_ff    <= o_val;
         rsp_held_ff   <= HELD_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[ring_wr_addr] <= ring_wr_data;
      end
      if (ring_rd_en) begin
         ring_rd_ff <= ring_mem[ring_rd_addr];
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - HELD_W - VAL_W - DEV_W)'(0),
                        rsp_held_ff, rsp_val_ff, rsp_dev_ff};

endmodule

/* src/ieqnf_dev_table.sv */
`timescale 1ns / 1ps
module ieqnf_dev_table #(
   parameter int NUM_DEVICES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [$clog2(NUM_DEVICES)-1:0]    rd_addr,
   output ieqnf_pkg::dev_rec_type            rd_data,
   input  logic                              wr_en,
   input  logic [$clog2(NUM_DEVICES)-1:0]    wr_addr,
   input  ieqnf_pkg::dev_rec_type            wr_data,
   output logic                              ready
);
   import ieqnf_pkg::*;

   localparam int AW = $clog2(NUM_DEVICES);

   dev_rec_type       mem [NUM_DEVICES];
   dev_rec_type       rd_data_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic [AW-1:0]     clr_addr_in;
   logic              ready_ff;
   logic              ready_in;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   dev_rec_type       mem_wdata;

   // zeroing sweep after reset, one entry per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      ready_in    = ready_ff;
      if (!ready_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(NUM_DEVICES - 1)) begin
            ready_in = 1'b1;
         end
      end
      mem_we    = ready_ff ? wr_en   : 1'b1;
      mem_waddr = ready_ff ? wr_addr : clr_addr_ff;
      mem_wdata = ready_ff ? wr_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         ready_ff    <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         ready_ff    <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ready_ff;

endmodule
